// ===== hdl/uri_cs_pkg.sv =====
// shared constants and types of the uri component splitter
`default_nettype none

package uri_cs_pkg;

    // longest text that is split; longer text is flagged
    localparam int MAX_LEN = 4096;
    // byte position, saturating one past the limit
    localparam int POS_W   = $clog2(MAX_LEN + 2);
    // width of the offset and length fields of a result
    localparam int FIELD_W = 13;
    localparam int CHAR_W  = 8;

    // characters the patterns care about
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // control from the top level to one match tracker
    typedef struct packed {
        logic              adv;
        logic              first;
        logic              start;
        logic              arm;
        logic              strict;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  len;
        logic [CHAR_W-1:0] ch;
    } t_trk_ctl;

    // split found by one tracker for the text seen so far
    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] auth_b;
        logic [POS_W-1:0] auth_l;
        logic [POS_W-1:0] path_b;
        logic [POS_W-1:0] path_l;
        logic [POS_W-1:0] q_b;
        logic [POS_W-1:0] q_l;
        logic [POS_W-1:0] f_b;
        logic [POS_W-1:0] f_l;
    } t_trk_res;

endpackage

`default_nettype wire

// ===== hdl/uri_cs_if.sv =====
// byte input channel and split result channel
`default_nettype none

interface uri_cs_in_if import uri_cs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface uri_cs_res_if import uri_cs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic               too_long;
    logic [FIELD_W-1:0] scheme_len;
    logic [FIELD_W-1:0] auth_begin;
    logic [FIELD_W-1:0] auth_len;
    logic [FIELD_W-1:0] path_begin;
    logic [FIELD_W-1:0] path_len;
    logic [FIELD_W-1:0] query_begin;
    logic [FIELD_W-1:0] query_len;
    logic [FIELD_W-1:0] frag_begin;
    logic [FIELD_W-1:0] frag_len;

    modport source (output valid, output valid_res, output too_long, output scheme_len,
                    output auth_begin, output auth_len, output path_begin, output path_len,
                    output query_begin, output query_len, output frag_begin,
                    output frag_len, input ready);
    modport sink   (input valid, input valid_res, input too_long, input scheme_len,
                    input auth_begin, input auth_len, input path_begin, input path_len,
                    input query_begin, input query_len, input frag_begin,
                    input frag_len, output ready);
endinterface

`default_nettype wire

// ===== hdl/uri_cs_tracker.sv =====
// tracks authority, path, query and fragment boundaries from one start position
`default_nettype none

module uri_cs_tracker import uri_cs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_trk_ctl i_ctl,
    output t_trk_res      o_res
);

    localparam int K_W = 3;
    localparam logic [K_W-1:0] K_FIRST  = K_W'(0);
    localparam logic [K_W-1:0] K_SECOND = K_W'(1);
    localparam logic [K_W-1:0] K_THIRD  = K_W'(2);
    localparam logic [K_W-1:0] K_FOURTH = K_W'(3);
    localparam logic [K_W-1:0] K_SAT    = K_W'(4);

    typedef struct packed {
        logic             act;
        logic [POS_W-1:0] a;
        logic [K_W-1:0]   k;
        logic             d0;
        logic             d1;
        logic             p0;
        logic             p1;
        logic             g2;
        logic             g3;
        logic             ea_fnd;
        logic             ea_sl;
        logic [POS_W-1:0] ea;
        logic             e_fnd;
        logic             e_q;
        logic [POS_W-1:0] e;
        logic             q_ne;
        logic             f_fnd;
        logic [POS_W-1:0] f;
        logic             f_ne;
        logic             bad;
    } t_st;

    t_st r_st;
    t_st st_b;
    t_st n_st;

    logic is_sl, is_q, is_h, is_sep, is_lf;

    assign is_sl  = (i_ctl.ch == CH_SLASH);
    assign is_q   = (i_ctl.ch == CH_QUEST);
    assign is_h   = (i_ctl.ch == CH_HASH);
    assign is_sep = is_q | is_h;
    assign is_lf  = (i_ctl.ch == CH_LF) | (i_ctl.ch == CH_CR);

    // per-byte update of the boundary flags and positions
    always_comb begin
        st_b = r_st;
        if (i_ctl.first) begin
            st_b = '0;
        end
        if (i_ctl.start) begin
            st_b     = '0;
            st_b.act = 1'b1;
            st_b.a   = i_ctl.pos;
        end
        if (i_ctl.arm) begin
            st_b     = '0;
            st_b.act = 1'b1;
            st_b.a   = i_ctl.pos + POS_W'(1);
        end
        n_st = st_b;
        if (st_b.act && !i_ctl.arm) begin
            case (st_b.k)
                K_FIRST: begin
                    n_st.d0 = is_sl;
                    n_st.p0 = !is_sep;
                end
                K_SECOND: begin
                    n_st.d1 = is_sl;
                    n_st.p1 = !is_sep;
                end
                K_THIRD: begin
                    n_st.g2 = !(is_sl | is_sep);
                end
                K_FOURTH: begin
                    n_st.g3 = st_b.g2 && !(is_sl | is_sep);
                end
                default: begin
                end
            endcase
            // end of the authority candidate
            if ((st_b.k >= K_THIRD) && !st_b.ea_fnd && (is_sl | is_sep)) begin
                n_st.ea_fnd = 1'b1;
                n_st.ea_sl  = is_sl;
                n_st.ea     = i_ctl.pos;
            end
            // end of path, then query and fragment
            if (!st_b.e_fnd) begin
                if (is_sep) begin
                    n_st.e_fnd = 1'b1;
                    n_st.e_q   = is_q;
                    n_st.e     = i_ctl.pos;
                end
                if (is_h) begin
                    n_st.f_fnd = 1'b1;
                    n_st.f     = i_ctl.pos;
                end
            end else begin
                if (st_b.e_q && !st_b.f_fnd) begin
                    if (is_h) begin
                        n_st.f_fnd = 1'b1;
                        n_st.f     = i_ctl.pos;
                    end else begin
                        n_st.q_ne = 1'b1;
                    end
                end
                if (st_b.f_fnd) begin
                    n_st.f_ne = 1'b1;
                    if (is_lf) begin
                        n_st.bad = 1'b1;
                    end
                end
            end
            if (st_b.k != K_SAT) begin
                n_st.k = st_b.k + K_W'(1);
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_ctl.adv) begin
            r_st <= n_st;
        end
    end

    // split for the text up to and including the current byte
    always_comb begin
        logic [POS_W-1:0] e_end;
        logic [POS_W-1:0] f_end;
        logic [POS_W-1:0] ea_end;
        logic [POS_W-1:0] a_end;
        logic [POS_W-1:0] pb;
        logic [POS_W-1:0] auth_st;
        logic             tail;
        logic             pok;
        logic             auth;
        e_end   = n_st.e_fnd ? n_st.e : i_ctl.len;
        f_end   = n_st.f_fnd ? n_st.f : i_ctl.len;
        ea_end  = n_st.ea_fnd ? n_st.ea : i_ctl.len;
        auth_st = n_st.a + POS_W'(2);
        a_end   = ea_end;
        pb      = n_st.a;
        pok     = 1'b1;
        auth    = 1'b0;
        // query and fragment tail
        if (!n_st.e_fnd) begin
            tail = 1'b1;
        end else if (n_st.e_q) begin
            tail = n_st.q_ne && (!n_st.f_fnd || (n_st.f_ne && !n_st.bad));
        end else begin
            tail = n_st.f_ne && !n_st.bad;
        end
        // authority and path choice
        if (n_st.d0 && n_st.d1) begin
            if (n_st.g2 && (!i_ctl.strict || n_st.ea_sl)) begin
                auth = 1'b1;
                pb   = ea_end;
            end else if (i_ctl.strict && n_st.g3) begin
                auth  = 1'b1;
                a_end = ea_end - POS_W'(1);
                pb    = a_end;
            end else begin
                pb = n_st.a + POS_W'(1);
            end
        end else if (i_ctl.strict) begin
            if (n_st.d0 && n_st.p1) begin
                pb = n_st.a + POS_W'(1);
            end else if (!n_st.p0) begin
                pok = 1'b0;
            end
        end else if (n_st.d0) begin
            pb = n_st.a + POS_W'(1);
        end
        o_res.ok     = tail && pok;
        o_res.auth_b = auth ? auth_st : i_ctl.len;
        o_res.auth_l = auth ? (a_end - auth_st) : '0;
        o_res.path_b = pb;
        o_res.path_l = e_end - pb;
        if (n_st.e_fnd && n_st.e_q) begin
            o_res.q_b = n_st.e + POS_W'(1);
            o_res.q_l = f_end - n_st.e - POS_W'(1);
        end else begin
            o_res.q_b = i_ctl.len;
            o_res.q_l = '0;
        end
        if (n_st.f_fnd) begin
            o_res.f_b = n_st.f + POS_W'(1);
            o_res.f_l = i_ctl.len - n_st.f - POS_W'(1);
        end else begin
            o_res.f_b = i_ctl.len;
            o_res.f_l = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/uri_component_splitter_core.sv =====
// top level of the uri component splitter
//
//  channel  | dir | transfer                | content
//  i_in     | in  | one byte of uri text    | char_byte, last_byte
//  o_res    | out | one split per uri       | valid_res, too_long, offsets, lengths
//  i_cfg_*  | in  | write, no handshake     | strict_mode
//
// one byte per cycle unless a last byte waits; each byte is held in the input
// register, and the split is loaded into the output register as the last byte
// is taken. two trackers, one from position 0 and one after the first colon,
// follow every byte as it leaves the input register. reset is synchronous and
// clears control state; strict_mode resets to 1. a last byte waits in the input
// register only while an earlier split is still held in the output register.
`default_nettype none

module uri_component_splitter_core import uri_cs_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    uri_cs_in_if.sink   i_in,
    uri_cs_res_if.source o_res
);

    typedef struct packed {
        logic               valid_res;
        logic               too_long;
        logic [FIELD_W-1:0] scheme_len;
        logic [FIELD_W-1:0] auth_begin;
        logic [FIELD_W-1:0] auth_len;
        logic [FIELD_W-1:0] path_begin;
        logic [FIELD_W-1:0] path_len;
        logic [FIELD_W-1:0] query_begin;
        logic [FIELD_W-1:0] query_len;
        logic [FIELD_W-1:0] frag_begin;
        logic [FIELD_W-1:0] frag_len;
    } t_out;

    logic              r_strict;
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_ch;
    logic              r_in_last;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              r_cfound;
    logic              n_cfound;
    logic [POS_W-1:0]  r_c;
    logic [POS_W-1:0]  n_c;
    logic              r_out_vld;
    t_out              r_out;
    t_out              n_out;

    logic             adv;
    logic             first;
    logic [POS_W-1:0] len;
    logic             cf_b;
    logic             colon_here;
    t_trk_ctl         ctl0;
    t_trk_ctl         ctl1;
    t_trk_res         res0;
    t_trk_res         res1;

    // input stage advances unless a last byte meets a held split
    assign adv        = r_in_vld && (!r_in_last || !r_out_vld || o_res.ready);
    assign i_in.ready = !r_in_vld || adv;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_strict <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch   <= i_in.char_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // byte count and first colon
    always_comb begin
        first      = (r_pos == '0);
        len        = (r_pos <= POS_W'(MAX_LEN)) ? (r_pos + POS_W'(1)) : r_pos;
        n_pos      = r_in_last ? '0 : len;
        cf_b       = first ? 1'b0 : r_cfound;
        colon_here = (r_in_ch == CH_COLON) && !cf_b;
        n_cfound   = cf_b | colon_here;
        n_c        = colon_here ? r_pos : r_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cfound <= 1'b0;
            r_c      <= '0;
        end else if (adv) begin
            r_pos    <= n_pos;
            r_cfound <= n_cfound;
            r_c      <= n_c;
        end
    end

    // tracker from position 0 and tracker after the first colon
    always_comb begin
        ctl0.adv    = adv;
        ctl0.first  = first;
        ctl0.start  = first;
        ctl0.arm    = 1'b0;
        ctl0.strict = r_strict;
        ctl0.pos    = r_pos;
        ctl0.len    = len;
        ctl0.ch     = r_in_ch;
        ctl1        = ctl0;
        ctl1.start  = 1'b0;
        ctl1.arm    = colon_here;
    end

    uri_cs_tracker u_trk_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl0),
        .o_res   (res0)
    );

    uri_cs_tracker u_trk_scheme (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl1),
        .o_res   (res1)
    );

    // pick the split and form the result
    always_comb begin
        logic     c_ok;
        logic     use1;
        logic     ok;
        logic     over;
        logic     good;
        t_trk_res sel;
        c_ok  = n_cfound && (n_c != '0);
        use1  = r_strict || (c_ok && res1.ok);
        ok    = r_strict ? (c_ok && res1.ok) : (use1 || res0.ok);
        sel   = use1 ? res1 : res0;
        over  = (len > POS_W'(MAX_LEN));
        good  = ok && !over;
        n_out = '0;
        n_out.too_long  = over;
        n_out.valid_res = good;
        if (good) begin
            n_out.scheme_len  = use1 ? FIELD_W'(n_c) : '0;
            n_out.auth_begin  = FIELD_W'(sel.auth_b);
            n_out.auth_len    = FIELD_W'(sel.auth_l);
            n_out.path_begin  = FIELD_W'(sel.path_b);
            n_out.path_len    = FIELD_W'(sel.path_l);
            n_out.query_begin = FIELD_W'(sel.q_b);
            n_out.query_len   = FIELD_W'(sel.q_l);
            n_out.frag_begin  = FIELD_W'(sel.f_b);
            n_out.frag_len    = FIELD_W'(sel.f_l);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.valid_res   = r_out.valid_res;
    assign o_res.too_long    = r_out.too_long;
    assign o_res.scheme_len  = r_out.scheme_len;
    assign o_res.auth_begin  = r_out.auth_begin;
    assign o_res.auth_len    = r_out.auth_len;
    assign o_res.path_begin  = r_out.path_begin;
    assign o_res.path_len    = r_out.path_len;
    assign o_res.query_begin = r_out.query_begin;
    assign o_res.query_len   = r_out.query_len;
    assign o_res.frag_begin  = r_out.frag_begin;
    assign o_res.frag_len    = r_out.frag_len;

endmodule

`default_nettype wire
